// File: rtl/vtbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbm_pkg
// Shared types and constants of the vertex transform and bounds merge block.
// ----------------------------------------------------------------------------
package vtbm_pkg;

  // Number format and counter width
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_WIDTH = 24;

  // Exact product and accumulator widths
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;

  // Stored matrix: three rows of each of four columns
  localparam int COEF_ROWS   = 3;
  localparam int COEF_COLS   = 4;
  localparam int COEF_COUNT  = COEF_ROWS * COEF_COLS;
  localparam int COEF_SEL_W  = $clog2(COEF_COUNT);

  // Decoupling queue, depth is a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    CMD_START_CLUSTER  = 3'd0,
    CMD_LOAD_COEFF     = 3'd1,
    CMD_START_INSTANCE = 3'd2,
    CMD_VERTEX         = 3'd3,
    CMD_INDEX          = 3'd4,
    CMD_END_CLUSTER    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_BASE,
    OP_VERTEX,
    OP_INDEX,
    OP_BOUNDS
  } op_e;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_INDEX  = 2'd1,
    KIND_BOUNDS = 2'd2
  } kind_e;

  localparam logic [1:0] ROW_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]                    cmd;
    logic [3:0]                    coeff_index;
    logic signed [COORD_WIDTH-1:0] coeff_value;
    logic signed [COORD_WIDTH-1:0] vert_x;
    logic signed [COORD_WIDTH-1:0] vert_y;
    logic signed [COORD_WIDTH-1:0] vert_z;
    logic [COUNT_WIDTH-1:0]        index_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] min_z;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
    logic signed [COORD_WIDTH-1:0] max_z;
    logic [COUNT_WIDTH-1:0]        out_index;
    logic [COUNT_WIDTH-1:0]        vertex_total;
  } out_item_t;

  // Decoded word held in the queue
  typedef struct packed {
    op_e                           op;
    logic [COEF_SEL_W-1:0]         coeff_sel;
    logic signed [COORD_WIDTH-1:0] coeff_value;
    logic signed [COORD_WIDTH-1:0] vert_x;
    logic signed [COORD_WIDTH-1:0] vert_y;
    logic signed [COORD_WIDTH-1:0] vert_z;
    logic [COUNT_WIDTH-1:0]        index_in;
  } q_item_t;

  // Control carried down the arithmetic pipeline
  typedef struct packed {
    op_e                    op;
    logic [COUNT_WIDTH-1:0] index_in;
  } ctl_t;

endpackage

// File: rtl/vtbm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbm_front
// Decodes an incoming word into a queue entry and drops words with no effect.
// ----------------------------------------------------------------------------
module vtbm_front (
  input  vtbm_pkg::in_item_t in_data_i,
  output logic               keep_o,
  output vtbm_pkg::q_item_t  item_o
);
  import vtbm_pkg::*;

  logic [1:0] col;
  logic [1:0] row;

  assign col = in_data_i.coeff_index[3:2];
  assign row = in_data_i.coeff_index[1:0];

  always_comb begin
    item_o             = '0;
    item_o.coeff_value = in_data_i.coeff_value;
    item_o.vert_x      = in_data_i.vert_x;
    item_o.vert_y      = in_data_i.vert_y;
    item_o.vert_z      = in_data_i.vert_z;
    item_o.index_in    = in_data_i.index_in;
    // column * 3 + row
    item_o.coeff_sel   = COEF_SEL_W'({col, 1'b0}) + COEF_SEL_W'(col) + COEF_SEL_W'(row);
    keep_o             = 1'b1;
    unique case (in_data_i.cmd)
      CMD_START_CLUSTER:  item_o.op = OP_CLEAR;
      CMD_LOAD_COEFF: begin
        item_o.op = OP_LOAD;
        // drop row-four entries
        keep_o    = (row != ROW_UNUSED);
      end
      CMD_START_INSTANCE: item_o.op = OP_BASE;
      CMD_VERTEX:         item_o.op = OP_VERTEX;
      CMD_INDEX:          item_o.op = OP_INDEX;
      CMD_END_CLUSTER:    item_o.op = OP_BOUNDS;
      default: begin
        item_o.op = OP_CLEAR;
        keep_o    = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/vtbm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbm_queue
// Short first-in first-out queue between the decode front and the datapath.
// ----------------------------------------------------------------------------
module vtbm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vtbm_pkg::q_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output vtbm_pkg::q_item_t item_o
);
  import vtbm_pkg::*;

  q_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q,  count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/vtbm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbm_back
// Matrix store, transform pipeline, cluster state and result register.
// ----------------------------------------------------------------------------
module vtbm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  vtbm_pkg::q_item_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vtbm_pkg::out_item_t out_data_o
);
  import vtbm_pkg::*;

  logic adv;

  logic signed [COORD_WIDTH-1:0] coef_q [COEF_COUNT];
  logic signed [COORD_WIDTH-1:0] head_vert [3];

  logic                          s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  ctl_t                          s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q;
  logic signed [PROD_WIDTH-1:0]  s1_prod_d [3][3];
  logic signed [PROD_WIDTH-1:0]  s1_prod_q [3][3];
  logic signed [COORD_WIDTH-1:0] s1_trans_q [3];
  logic signed [ACC_WIDTH-1:0]   s2_a_q [3];
  logic signed [ACC_WIDTH-1:0]   s2_b_q [3];
  logic signed [ACC_WIDTH-1:0]   s3_acc_q [3];
  logic signed [ACC_WIDTH-1:0]   s3_shift [3];
  logic [COORD_WIDTH-1:0]        s4_sat_d [3];
  logic [COORD_WIDTH-1:0]        s4_sat_q [3];

  logic signed [COORD_WIDTH-1:0] box_min_q [3];
  logic signed [COORD_WIDTH-1:0] box_min_d [3];
  logic signed [COORD_WIDTH-1:0] box_max_q [3];
  logic signed [COORD_WIDTH-1:0] box_max_d [3];
  logic [COUNT_WIDTH-1:0]        count_q, count_d, count_inc;
  logic [COUNT_WIDTH-1:0]        base_q, base_d;
  logic                          out_valid_q, out_valid_d;
  out_item_t                     out_q, out_d;

  // the whole pipeline moves as one while the result register can take a word
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && head_valid_i;

  assign head_vert[0] = head_i.vert_x;
  assign head_vert[1] = head_i.vert_y;
  assign head_vert[2] = head_i.vert_z;

  // matrix entries are read and written at pop, so loads stay in order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COEF_COUNT; i++) begin
        coef_q[i] <= '0;
      end
    end else if (pop_o && head_i.op == OP_LOAD) begin
      coef_q[head_i.coeff_sel] <= head_i.coeff_value;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s1_prod_d[r][c] = coef_q[c * COEF_ROWS + r] * head_vert[c];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s3_shift[r] = s3_acc_q[r] >>> FRAC_BITS;
      if (&s3_shift[r][ACC_WIDTH-1:COORD_WIDTH-1] ||
          ~|s3_shift[r][ACC_WIDTH-1:COORD_WIDTH-1]) begin
        s4_sat_d[r] = s3_shift[r][COORD_WIDTH-1:0];
      end else begin
        s4_sat_d[r] = s3_shift[r][ACC_WIDTH-1] ? COORD_MIN : COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q <= '{op: head_i.op, index_in: head_i.index_in};
      s2_ctl_q <= s1_ctl_q;
      s3_ctl_q <= s2_ctl_q;
      s4_ctl_q <= s3_ctl_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_prod_q[r][c] <= s1_prod_d[r][c];
        end
        s1_trans_q[r] <= coef_q[3 * COEF_ROWS + r];
        s2_a_q[r]     <= ACC_WIDTH'(s1_prod_q[r][0]) + ACC_WIDTH'(s1_prod_q[r][1]);
        s2_b_q[r]     <= ACC_WIDTH'(s1_prod_q[r][2]) +
                         ACC_WIDTH'($signed({s1_trans_q[r], {FRAC_BITS{1'b0}}}));
        s3_acc_q[r]   <= s2_a_q[r] + s2_b_q[r];
        s4_sat_q[r]   <= s4_sat_d[r];
      end
    end
  end

  // cluster state and the result word
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

  always_comb begin
    box_min_d   = box_min_q;
    box_max_d   = box_max_q;
    count_d     = count_q;
    base_d      = base_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = 1'b0;
      if (s4_valid_q) begin
        out_d = '0;
        case (s4_ctl_q.op)
          OP_CLEAR: begin
            for (int r = 0; r < 3; r++) begin
              box_min_d[r] = COORD_MAX;
              box_max_d[r] = COORD_MIN;
            end
            count_d = '0;
          end
          OP_BASE: begin
            base_d = count_q;
          end
          OP_VERTEX: begin
            for (int r = 0; r < 3; r++) begin
              if ($signed(s4_sat_q[r]) < box_min_q[r]) begin
                box_min_d[r] = $signed(s4_sat_q[r]);
              end
              if ($signed(s4_sat_q[r]) > box_max_q[r]) begin
                box_max_d[r] = $signed(s4_sat_q[r]);
              end
            end
            count_d            = count_inc;
            out_valid_d        = 1'b1;
            out_d.kind         = KIND_VERTEX;
            out_d.px           = s4_sat_q[0];
            out_d.py           = s4_sat_q[1];
            out_d.pz           = s4_sat_q[2];
            out_d.vertex_total = count_inc;
          end
          OP_INDEX: begin
            out_valid_d     = 1'b1;
            out_d.kind      = KIND_INDEX;
            out_d.out_index = s4_ctl_q.index_in + base_q;
          end
          OP_BOUNDS: begin
            out_valid_d        = 1'b1;
            out_d.kind         = KIND_BOUNDS;
            out_d.min_x        = box_min_q[0];
            out_d.min_y        = box_min_q[1];
            out_d.min_z        = box_min_q[2];
            out_d.max_x        = box_max_q[0];
            out_d.max_y        = box_max_q[1];
            out_d.max_z        = box_max_q[2];
            out_d.vertex_total = count_q;
          end
          default: begin
            out_valid_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        box_min_q[r] <= COORD_MAX;
        box_max_q[r] <= COORD_MIN;
      end
      count_q     <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      box_min_q   <= box_min_d;
      box_max_q   <= box_max_d;
      count_q     <= count_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/vertex_transform_bounds_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_bounds_merge
// Transforms vertices by an affine Q16.16 matrix, rebases indices and keeps
// the cluster bounding box and vertex count.
//
//   channel  | signals                           | direction
//   ---------+-----------------------------------+----------
//   input    | in_valid_i, in_ready_o, in_data_i | in
//   result   | out_valid_o, out_ready_i, out_data_o | out
//
// One word per cycle sustained while the result channel is not stalled. A kept
// input word is written into the queue, then popped into the stage-one products,
// then passes the partial sums, the full sum, the saturated stage and the result register.
// Reset clears the matrix, the counts, the box and all valid state at once.
// A stalled result freezes the pipeline; the four-entry queue keeps taking
// words until it fills, so in_ready_o depends only on queue occupancy.
// ----------------------------------------------------------------------------
module vertex_transform_bounds_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vtbm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vtbm_pkg::out_item_t out_data_o
);
  import vtbm_pkg::*;

  logic    keep;
  logic    push;
  logic    q_full;
  logic    q_valid;
  logic    pop;
  q_item_t dec_item;
  q_item_t head_item;

  vtbm_front u_front (
    .in_data_i (in_data_i),
    .keep_o    (keep),
    .item_o    (dec_item)
  );

  assign in_ready_o = !q_full;
  assign push       = in_valid_i && in_ready_o && keep;

  vtbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (dec_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  vtbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue read while empty");

  a_vertex_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_VERTEX |-> out_data_o.vertex_total != '0)
    else $error("vertex result with zero count");

  a_index_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_INDEX |->
      out_data_o.px == '0 && out_data_o.vertex_total == '0)
    else $error("index result carries stale fields");

endmodule
